// ----- rtl/gdd_pkg.sv -----
package gdd_pkg;

  localparam int CW        = 16;  // coordinate width, signed Q8.8
  localparam int IVW       = 16;  // inverse variance width, unsigned Q4.12
  localparam int SCW       = 32;  // scale / density width, unsigned Q16.16
  localparam int XQ_SHIFT  = 13;  // Q.29 -> Q.16
  localparam int XQ_W      = 22;  // exponent below 64.0 in Q.16
  localparam int LOG2E_W   = 31;
  localparam int LOG2E_SH  = 30;
  localparam int FR_W      = 16;
  localparam int IP_W      = 5;   // shift of 32 + ip stays below 64
  localparam int F_W       = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN_X    = 3'd0,
    REG_MEAN_Y    = 3'd1,
    REG_INV_VAR_X = 3'd2,
    REG_INV_VAR_Y = 3'd3,
    REG_SCALE     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic            big;
    logic [XQ_W-1:0] xq;
  } expn_t;

  typedef struct packed {
    logic            zero;
    logic [IP_W-1:0] ip;
    logic [F_W-1:0]  f;
  } frac_t;

  typedef struct packed {
    logic            zero;
    logic [IP_W-1:0] ip;
    logic            one;   // mantissa is exactly 1.0
    logic [31:0]     v;
  } mant_t;

  typedef logic [31:0] root_arr_t [0:F_W];

  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] b;
    int          j;
    a = a_in;
    r = '0;
    b = 64'd1 << 62;
    for (j = 0; j < 32; j++) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // ROOT[i] = 2^(-2^-i) in Q0.32
  function automatic root_arr_t root_table();
    root_arr_t   t;
    logic [63:0] x;
    int          i;
    t[0] = 32'h8000_0000;
    for (i = 1; i <= F_W; i++) begin
      x    = isqrt64({t[i-1], 32'h0});
      t[i] = x[31:0];
    end
    return t;
  endfunction

  localparam root_arr_t ROOT = root_table();

endpackage

// ----- rtl/gaussian_diag_2d_density_core.sv -----
// Pipeline: 26 register stages. Throughput: one request per cycle while out_tready
// does not hold the pipeline; every stage holds at most one 32x32 multiply.
// Stalls propagate stage by stage, so bubbles fill and nothing is dropped.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// configuration registers to their defaults.
module gaussian_diag_2d_density_core import gdd_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // point_x, point_y, given_mean_x, given_mean_y
  input  logic                 in_tuser,   // use_given_mean
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SCW-1:0]       out_tdata,  // density
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int NS = 2;

  logic signed [CW-1:0] mean_x_r, mean_y_r;
  logic [IVW-1:0]       inv_var_x_r, inv_var_y_r;
  logic [SCW-1:0]       scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_x_r    <= '0;
      mean_y_r    <= '0;
      inv_var_x_r <= IVW'(4096);
      inv_var_y_r <= IVW'(4096);
      scale_r     <= SCW'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MEAN_X:    mean_x_r    <= cfg_wdata[CW-1:0];
        REG_MEAN_Y:    mean_y_r    <= cfg_wdata[CW-1:0];
        REG_INV_VAR_X: inv_var_x_r <= cfg_wdata[IVW-1:0];
        REG_INV_VAR_Y: inv_var_y_r <= cfg_wdata[IVW-1:0];
        REG_SCALE:     scale_r     <= cfg_wdata[SCW-1:0];
        default: ;
      endcase
    end
  end

  logic  q_vld, q_rdy, e_vld, e_rdy, m_vld, m_rdy;
  expn_t q_data;
  frac_t e_data;
  mant_t m_data;

  gdd_quad u_quad (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .point_x        (in_tdata[15:0]),
    .point_y        (in_tdata[31:16]),
    .use_given_mean (in_tuser),
    .given_mean_x   (in_tdata[47:32]),
    .given_mean_y   (in_tdata[63:48]),
    .mean_x         (mean_x_r),
    .mean_y         (mean_y_r),
    .inv_var_x      (inv_var_x_r),
    .inv_var_y      (inv_var_y_r),
    .out_valid      (q_vld),
    .out_ready      (q_rdy),
    .out_data       (q_data)
  );

  gdd_expo #(
    .ENTRIES (EXP_TABLE_ENTRIES)
  ) u_expo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_vld),
    .in_ready  (q_rdy),
    .in_data   (q_data),
    .out_valid (e_vld),
    .out_ready (e_rdy),
    .out_data  (e_data)
  );

  gdd_pow2 u_pow2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_vld),
    .in_ready  (e_rdy),
    .in_data   (e_data),
    .out_valid (m_vld),
    .out_ready (m_rdy),
    .out_data  (m_data)
  );

  logic [NS-1:0]   vld_r;
  logic [NS:0]     rdy;
  logic [63:0]     prod_r;
  logic            zp_r;
  logic [IP_W-1:0] ipp_r;
  logic [SCW-1:0]  dens_r;

  always_comb begin
    rdy[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= m_vld;
      if (rdy[1]) vld_r[1] <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod_r <= m_data.one ? {scale_r, 32'h0} : 64'(scale_r) * 64'(m_data.v);
      zp_r   <= m_data.zero;
      ipp_r  <= m_data.ip;
    end
    if (rdy[1]) begin
      dens_r <= zp_r ? '0 : (prod_r[63:32] >> ipp_r);
    end
  end

  assign m_rdy      = rdy[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = dens_r;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy[1] && vld_r[0] && zp_r) |=> (out_tdata == '0))
    else $error("large exponent did not give zero density");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("request refused while pipeline can move");

endmodule

// ----- rtl/gdd_quad.sv -----
module gdd_quad import gdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [CW-1:0]  point_x,
  input  logic signed [CW-1:0]  point_y,
  input  logic                  use_given_mean,
  input  logic signed [CW-1:0]  given_mean_x,
  input  logic signed [CW-1:0]  given_mean_y,
  input  logic signed [CW-1:0]  mean_x,
  input  logic signed [CW-1:0]  mean_y,
  input  logic [IVW-1:0]        inv_var_x,
  input  logic [IVW-1:0]        inv_var_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output expn_t                 out_data
);

  localparam int NS = 4;
  localparam int SQW = 2 * CW;
  localparam int WW  = IVW + SQW;
  localparam int SW  = WW + 1;

  logic [NS-1:0] vld_r;
  logic [NS:0]   rdy;

  logic signed [CW-1:0] mx, my;
  logic signed [CW:0]   dx, dy, ndx, ndy;
  logic [CW-1:0]        adx, ady;
  logic [CW-1:0]        adx_r, ady_r;
  logic [SQW-1:0]       sqx_r, sqy_r;
  logic [WW-1:0]        wx_r, wy_r;
  logic [SW-1:0]        s;
  expn_t                out_r;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    mx  = use_given_mean ? given_mean_x : mean_x;
    my  = use_given_mean ? given_mean_y : mean_y;
    dx  = (CW+1)'(point_x) - (CW+1)'(mx);
    dy  = (CW+1)'(point_y) - (CW+1)'(my);
    ndx = -dx;
    ndy = -dy;
    adx = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
    ady = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
    s   = SW'(wx_r) + SW'(wy_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      adx_r <= adx;
      ady_r <= ady;
    end
    if (rdy[1]) begin
      sqx_r <= SQW'(adx_r) * SQW'(adx_r);
      sqy_r <= SQW'(ady_r) * SQW'(ady_r);
    end
    if (rdy[2]) begin
      wx_r <= WW'(inv_var_x) * WW'(sqx_r);
      wy_r <= WW'(inv_var_y) * WW'(sqy_r);
    end
    if (rdy[3]) begin
      out_r.big <= |s[SW-1:XQ_SHIFT+XQ_W];
      out_r.xq  <= s[XQ_SHIFT+XQ_W-1:XQ_SHIFT];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];
  assign out_data  = out_r;

endmodule

// ----- rtl/gdd_expo.sv -----
module gdd_expo import gdd_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  expn_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output frac_t out_data
);

  localparam int NS       = 4;
  localparam int IW       = $clog2(ENTRIES);
  localparam int EW       = $clog2(ENTRIES + 1);
  localparam int YPW      = XQ_W + LOG2E_W;
  localparam int YW       = YPW - LOG2E_SH;
  localparam int IPFW     = YW - FR_W;
  localparam int RECIP_SH = 29;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / ENTRIES;
  localparam int RW       = $clog2(RECIP + 1);
  localparam int PW       = (IW + RW > RECIP_SH) ? IW + RW : RECIP_SH;
  localparam int NW       = IW + F_W + 1;

  logic [NS-1:0] vld_r;
  logic [NS:0]   rdy;

  logic [YPW-1:0]       yp;
  logic [YW-1:0]        y;
  logic [IPFW-1:0]      ipf;
  logic [FR_W+EW-1:0]   ep;
  logic [PW-1:0]        qp;
  logic [NW-1:0]        num, qn, rem;

  logic                 zero0_r, zero1_r, zero2_r;
  logic [IP_W-1:0]      ip0_r, ip1_r, ip2_r;
  logic [FR_W-1:0]      fr_r;
  logic [IW-1:0]        idx1_r, idx2_r;
  logic [F_W-1:0]       q0_r;
  frac_t                out_r;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    yp  = YPW'(in_data.xq) * YPW'(LOG2E_Q30);
    y   = yp[YPW-1:LOG2E_SH];
    ipf = y[YW-1:FR_W];
    ep  = (FR_W+EW)'(fr_r) * (FR_W+EW)'(ENTRIES);
    qp  = PW'(idx1_r) * PW'(RECIP);
    num = NW'({idx2_r, {F_W{1'b0}}});
    qn  = NW'(q0_r) * NW'(ENTRIES);
    rem = num - qn;
  end

  // f = floor(idx * 2^16 / ENTRIES): reciprocal estimate, then one correction
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      zero0_r <= in_data.big || (|ipf[IPFW-1:IP_W]);
      ip0_r   <= ipf[IP_W-1:0];
      fr_r    <= y[FR_W-1:0];
    end
    if (rdy[1]) begin
      zero1_r <= zero0_r;
      ip1_r   <= ip0_r;
      idx1_r  <= ep[FR_W+IW-1:FR_W];
    end
    if (rdy[2]) begin
      zero2_r <= zero1_r;
      ip2_r   <= ip1_r;
      idx2_r  <= idx1_r;
      q0_r    <= qp[RECIP_SH-1:RECIP_SH-F_W];
    end
    if (rdy[3]) begin
      out_r.zero <= zero2_r;
      out_r.ip   <= ip2_r;
      out_r.f    <= q0_r + F_W'(rem >= NW'(ENTRIES));
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];
  assign out_data  = out_r;

endmodule

// ----- rtl/gdd_pow2.sv -----
module gdd_pow2 import gdd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  frac_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output mant_t out_data
);

  localparam int NS = F_W;

  typedef struct packed {
    logic            zero;
    logic [IP_W-1:0] ip;
    logic [F_W-1:0]  f;
    logic            one;
    logic [31:0]     v;
  } pw_t;

  logic [NS-1:0] vld_r;
  logic [NS:0]   rdy;
  pw_t           stg_r [NS];

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage k multiplies by 2^(-2^-(k+1)) when that bit of f is set
  for (genvar k = 0; k < NS; k++) begin : g_stage
    pw_t         src;
    pw_t         stg_nxt;
    logic [63:0] prod;

    if (k == 0) begin : g_first
      assign src = '{zero: in_data.zero, ip: in_data.ip, f: in_data.f,
                     one: 1'b1, v: 32'h0};
    end else begin : g_rest
      assign src = stg_r[k-1];
    end

    always_comb begin
      prod    = 64'(src.v) * 64'(ROOT[k+1]);
      stg_nxt = src;
      if (src.f[F_W-1-k]) begin
        stg_nxt.one = 1'b0;
        stg_nxt.v   = src.one ? ROOT[k+1] : prod[63:32];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) stg_r[k] <= stg_nxt;
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = vld_r[NS-1];
  assign out_data.zero = stg_r[NS-1].zero;
  assign out_data.ip   = stg_r[NS-1].ip;
  assign out_data.one  = stg_r[NS-1].one;
  assign out_data.v    = stg_r[NS-1].v;

endmodule
